FILE: sv/dcm_pkg.sv
// ============================================================================
// dcm_pkg
// Shared types and constants of the dual-CPU mailbox: transaction structs,
// decoded operations, register masks and bit positions.
// ============================================================================
package dcm_pkg;

    localparam logic [2:0] ACT_RD_SYNC = 3'd0;
    localparam logic [2:0] ACT_WR_SYNC = 3'd1;
    localparam logic [2:0] ACT_RD_CTL  = 3'd2;
    localparam logic [2:0] ACT_WR_CTL  = 3'd3;
    localparam logic [2:0] ACT_PUSH    = 3'd4;
    localparam logic [2:0] ACT_POP     = 3'd5;

    localparam logic [15:0] SYNC_WMASK = 16'h6F00;
    localparam logic [15:0] CTL_WMASK  = 16'h8404;
    localparam logic [15:0] CTL_RESET  = 16'h0101;

    localparam int SYNC_SEND = 13;
    localparam int SYNC_IEN  = 14;

    localparam int C_SEMPTY = 0;
    localparam int C_SFULL  = 1;
    localparam int C_SIRQ   = 2;
    localparam int C_CLEAR  = 3;
    localparam int C_REMPTY = 8;
    localparam int C_RFULL  = 9;
    localparam int C_RIRQ   = 10;
    localparam int C_ERROR  = 14;
    localparam int C_ENABLE = 15;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RD_SYNC,
        OP_WR_SYNC,
        OP_RD_CTL,
        OP_WR_CTL,
        OP_PUSH,
        OP_POP
    } op_t;

    typedef enum logic {
        EX_RUN,
        EX_POP
    } exec_state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic        side;
        logic [31:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  irq_sync;
        logic [1:0]  irq_send_empty;
        logic [1:0]  irq_recv_nonempty;
    } out_item_t;

    typedef struct packed {
        op_t         op;
        logic        side;
        logic [31:0] data;
    } op_item_t;

endpackage

FILE: sv/dcm_front.sv
// ============================================================================
// dcm_front
// Accepts access transactions, decodes the action into an operation and
// holds decoded operations in a two-entry queue for the execution unit.
// ============================================================================
module dcm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  dcm_pkg::in_item_t item,
    output logic              op_valid,
    output dcm_pkg::op_item_t op_item,
    input  logic              op_take
);
    import dcm_pkg::*;

    op_item_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    op_item_t   dec;
    logic       wr_en;
    logic       rd_en;

    always_comb
    begin
        dec.side = item.side;
        dec.data = item.write_data;
        unique case (item.action)
            ACT_RD_SYNC: dec.op = OP_RD_SYNC;
            ACT_WR_SYNC: dec.op = OP_WR_SYNC;
            ACT_RD_CTL:  dec.op = OP_RD_CTL;
            ACT_WR_CTL:  dec.op = OP_WR_CTL;
            ACT_PUSH:    dec.op = OP_PUSH;
            ACT_POP:     dec.op = OP_POP;
            default:     dec.op = OP_NONE;
        endcase
    end

    assign full     = (cnt_reg == 2'd2);
    assign op_valid = (cnt_reg != 2'd0);
    assign op_item  = slot_reg[rd_ptr_reg];
    assign wr_en    = push && !full;
    assign rd_en    = op_take && op_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

FILE: sv/dcm_out_q.sv
// ============================================================================
// dcm_out_q
// Two-entry result queue between the execution unit and the result port.
// ============================================================================
module dcm_out_q (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  dcm_pkg::out_item_t wr_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output dcm_pkg::out_item_t result
);
    import dcm_pkg::*;

    out_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign full   = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign result = slot_reg[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

FILE: sv/dcm_exec.sv
// ============================================================================
// dcm_exec
// Execution unit: sync and control registers of both CPUs, the two send
// FIFOs in one word memory, receive latches and interrupt generation.
// ============================================================================
module dcm_exec #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  dcm_pkg::op_item_t  op_item,
    output logic               op_take,
    input  logic               res_full,
    output logic               res_push,
    output dcm_pkg::out_item_t res_item
);
    import dcm_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [CW-1:0] CNT_FULL  = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] CNT_LAST  = CW'(FIFO_DEPTH - 1);
    localparam logic [SW-1:0] SUM_DEPTH = SW'(FIFO_DEPTH);
    localparam logic [AW-1:0] HEAD_LAST = AW'(FIFO_DEPTH - 1);

    exec_state_t   state_reg, state_next;
    logic [15:0]   sync_reg  [2];
    logic [15:0]   sync_next [2];
    logic [15:0]   ctl_reg   [2];
    logic [15:0]   ctl_next  [2];
    logic [CW-1:0] count_reg [2];
    logic [CW-1:0] count_next[2];
    logic [AW-1:0] head_reg  [2];
    logic [AW-1:0] head_next [2];
    logic [31:0]   latch_reg [2];
    logic [31:0]   latch_next[2];
    out_item_t     pend_reg, pend_next;
    logic          hit_reg, hit_next;
    logic          pside_reg, pside_next;

    logic [31:0]   word_mem [2**SW];
    logic [31:0]   rdata_reg;
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic          mem_re;
    logic [SW-1:0] mem_raddr;
    logic          run;

    assign run = (state_reg == EX_RUN) && op_valid && !res_full;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EX_RUN:
            begin
                if (run && op_item.op == OP_POP)
                begin
                    state_next = EX_POP;
                end
            end
            EX_POP:  state_next = EX_RUN;
            default: state_next = EX_RUN;
        endcase
    end

    always_comb
    begin
        op_take  = 1'b0;
        res_push = 1'b0;
        unique case (state_reg)
            EX_RUN:
            begin
                op_take  = run;
                res_push = run && (op_item.op != OP_POP);
            end
            EX_POP:  res_push = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        logic          me;
        logic          peer;
        logic [15:0]   v;
        logic [15:0]   c;
        logic [15:0]   old;
        logic [SW-1:0] sum;
        logic [AW-1:0] slot;
        logic [31:0]   d;

        me    = op_item.side;
        peer  = ~op_item.side;
        d     = op_item.data;
        v     = '0;
        c     = '0;
        old   = '0;
        sum   = '0;
        slot  = '0;
        for (int i = 0; i < 2; i++)
        begin
            sync_next[i]  = sync_reg[i];
            ctl_next[i]   = ctl_reg[i];
            count_next[i] = count_reg[i];
            head_next[i]  = head_reg[i];
            latch_next[i] = latch_reg[i];
        end
        pend_next  = pend_reg;
        hit_next   = hit_reg;
        pside_next = pside_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        res_item   = '0;

        if (state_reg == EX_POP)
        begin
            res_item = pend_reg;
            if (hit_reg)
            begin
                res_item.read_data   = rdata_reg;
                latch_next[pside_reg] = rdata_reg;
            end
            else
            begin
                res_item.read_data = latch_reg[pside_reg];
            end
        end
        else if (run)
        begin
            case (op_item.op)
                OP_RD_SYNC:
                begin
                    res_item.read_data = {16'h0000, sync_reg[me]};
                end
                OP_WR_SYNC:
                begin
                    v = (sync_reg[me] & ~SYNC_WMASK) | (d[15:0] & SYNC_WMASK);
                    sync_next[me]   = v;
                    sync_next[peer] = {sync_reg[peer][15:4], v[11:8]};
                    if (v[SYNC_SEND] && sync_reg[peer][SYNC_IEN])
                    begin
                        res_item.irq_sync[peer] = 1'b1;
                    end
                end
                OP_RD_CTL:
                begin
                    res_item.read_data = {16'h0000, ctl_reg[me]};
                end
                OP_WR_CTL:
                begin
                    old = ctl_reg[me];
                    c   = (old & ~CTL_WMASK) | (d[15:0] & CTL_WMASK);
                    if (d[C_CLEAR])
                    begin
                        count_next[me] = '0;
                        head_next[me]  = '0;
                        c[C_SEMPTY]    = 1'b1;
                        c[C_SFULL]     = 1'b0;
                        ctl_next[peer][C_REMPTY] = 1'b1;
                        ctl_next[peer][C_RFULL]  = 1'b0;
                        if (c[C_SIRQ])
                        begin
                            res_item.irq_send_empty[me] = 1'b1;
                        end
                    end
                    if (!old[C_SIRQ] && c[C_SIRQ] && c[C_SEMPTY])
                    begin
                        res_item.irq_send_empty[me] = 1'b1;
                    end
                    if (!old[C_RIRQ] && c[C_RIRQ] && !c[C_REMPTY])
                    begin
                        res_item.irq_recv_nonempty[me] = 1'b1;
                    end
                    if (d[C_ERROR])
                    begin
                        c[C_ERROR] = 1'b0;
                    end
                    ctl_next[me] = c;
                end
                OP_PUSH:
                begin
                    if (ctl_reg[me][C_ENABLE])
                    begin
                        if (count_reg[me] < CNT_FULL)
                        begin
                            sum  = SW'(head_reg[me]) + SW'(count_reg[me]);
                            slot = (sum >= SUM_DEPTH) ? AW'(sum - SUM_DEPTH) : AW'(sum);
                            mem_we         = 1'b1;
                            mem_waddr      = {me, slot};
                            count_next[me] = count_reg[me] + CW'(1);
                            if (count_reg[me] == '0)
                            begin
                                ctl_next[me][C_SEMPTY]   = 1'b0;
                                ctl_next[peer][C_REMPTY] = 1'b0;
                                if (ctl_reg[peer][C_RIRQ])
                                begin
                                    res_item.irq_recv_nonempty[peer] = 1'b1;
                                end
                            end
                            else if (count_reg[me] == CNT_LAST)
                            begin
                                ctl_next[me][C_SFULL]   = 1'b1;
                                ctl_next[peer][C_RFULL] = 1'b1;
                            end
                        end
                        else
                        begin
                            ctl_next[me][C_ERROR] = 1'b1;
                        end
                    end
                end
                OP_POP:
                begin
                    pside_next = me;
                    pend_next  = '0;
                    hit_next   = (count_reg[peer] != '0);
                    if (count_reg[peer] != '0)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = {peer, head_reg[peer]};
                        if (ctl_reg[me][C_ENABLE])
                        begin
                            head_next[peer]  = (head_reg[peer] == HEAD_LAST) ? '0 :
                                               head_reg[peer] + AW'(1);
                            count_next[peer] = count_reg[peer] - CW'(1);
                            if (count_reg[peer] == CW'(1))
                            begin
                                ctl_next[peer][C_SEMPTY] = 1'b1;
                                ctl_next[me][C_REMPTY]   = 1'b1;
                                if (ctl_reg[peer][C_SIRQ])
                                begin
                                    pend_next.irq_send_empty[peer] = 1'b1;
                                end
                            end
                            else if (count_reg[peer] == CNT_FULL)
                            begin
                                ctl_next[peer][C_SFULL] = 1'b0;
                                ctl_next[me][C_RFULL]   = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        ctl_next[me][C_ERROR] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            word_mem[mem_waddr] <= op_item.data;
        end
        if (mem_re)
        begin
            rdata_reg <= word_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        pside_reg <= pside_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EX_RUN;
            hit_reg   <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                sync_reg[i]  <= '0;
                ctl_reg[i]   <= CTL_RESET;
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                latch_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
            for (int i = 0; i < 2; i++)
            begin
                sync_reg[i]  <= sync_next[i];
                ctl_reg[i]   <= ctl_next[i];
                count_reg[i] <= count_next[i];
                head_reg[i]  <= head_next[i];
                latch_reg[i] <= latch_next[i];
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[0] <= CNT_FULL) && (count_reg[1] <= CNT_FULL))
        else $error("send FIFO count beyond depth");

    a_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg[0][C_SEMPTY] == (count_reg[0] == '0)) &&
        (ctl_reg[1][C_REMPTY] == (count_reg[0] == '0)) &&
        (ctl_reg[1][C_SEMPTY] == (count_reg[1] == '0)) &&
        (ctl_reg[0][C_REMPTY] == (count_reg[1] == '0)))
        else $error("empty flags disagree with FIFO count");

    a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg[0][C_SFULL] == (count_reg[0] == CNT_FULL)) &&
        (ctl_reg[1][C_RFULL] == (count_reg[0] == CNT_FULL)) &&
        (ctl_reg[1][C_SFULL] == (count_reg[1] == CNT_FULL)) &&
        (ctl_reg[0][C_RFULL] == (count_reg[1] == CNT_FULL)))
        else $error("full flags disagree with FIFO count");

    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EX_POP) |-> !res_full)
        else $error("pop result has no room in result queue");

    a_clear_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl_reg[0][C_CLEAR] && !ctl_reg[1][C_CLEAR])
        else $error("clear bit stored in control register");

endmodule

FILE: sv/dual_cpu_ipc_fifo_mailbox_unit.sv
// ============================================================================
// dual_cpu_ipc_fifo_mailbox_unit
// Interprocessor mailbox between two CPUs: sync registers, send FIFOs with
// control registers, and interrupt pulses reported with each access.
// ----------------------------------------------------------------------------
// Usage:
//   Access channel: drive item and raise push; the transaction is taken on
//   a clock edge where push is high and full is low. Each access names the
//   CPU side and one action (sync/control read or write, word push or pop).
//   Result channel: while empty is low, result carries the oldest result;
//   raise pop to take it. Every access returns exactly one result, in order.
//   Path: a result passes through the access queue, the execution unit and
//   the result queue; a word pop also waits on the registered read of the
//   FIFO word memory. Throughput: one access per cycle while the result
//   queue has room, except a word pop, which also holds the unit in EX_POP.
//   Reset: both FIFOs empty, control registers 0x0101, sync registers and
//   receive latches zero; no clearing pass is needed.
//   Receiver stall: a two-entry result queue and a two-entry access queue
//   absorb the stall; full rises once both fill, and nothing is dropped.
// ============================================================================
module dual_cpu_ipc_fifo_mailbox_unit #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  dcm_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output dcm_pkg::out_item_t result
);
    import dcm_pkg::*;

    logic      op_valid;
    op_item_t  op_item;
    logic      op_take;
    logic      res_full;
    logic      res_push;
    out_item_t res_item;

    dcm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_valid (op_valid),
        .op_item  (op_item),
        .op_take  (op_take)
    );

    dcm_exec #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_item  (op_item),
        .op_take  (op_take),
        .res_full (res_full),
        .res_push (res_push),
        .res_item (res_item)
    );

    dcm_out_q u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_item (res_item),
        .full    (res_full),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

FILE: dv/dual_cpu_ipc_fifo_mailbox_unit_test.sv
// ============================================================================
// dual_cpu_ipc_fifo_mailbox_unit_test
// Drives bus accesses from both CPU sides into the mailbox. A local mirror of
// the sync registers, control registers and send FIFOs predicts every result.
// Covers directed corner cases, a long receiver stall that fills the block,
// a pause until all results return, and random traffic with FIFO bursts.
// ============================================================================
module dual_cpu_ipc_fifo_mailbox_unit_test;
    import dcm_pkg::*;

    localparam int DEPTH        = 16;
    localparam int MAX_GAP      = 13;
    localparam int RANDOM_ITEMS = 1050;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 10;
    localparam int SHOW_LIMIT   = 10;

    localparam logic [2:0] ACT_RESERVED_LO = 3'd6;
    localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  item;
    logic      empty;
    logic      pop;
    out_item_t result;

    logic [15:0] sync_q [0:1];
    logic [15:0] ctl_q [0:1];
    logic [31:0] fifo_mem [0:1][0:DEPTH-1];
    logic [4:0]  fill_q [0:1];
    logic [3:0]  head_q [0:1];
    logic [31:0] latch_q [0:1];

    out_item_t outcome_q [$];
    int        fail_count;
    int        sent;
    int        rx_hold_req;
    bit        tx_steady;
    bit        rx_steady;

    dual_cpu_ipc_fifo_mailbox_unit #(
        .FIFO_DEPTH(DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic out_item_t mailbox_outcome(input in_item_t t);
        out_item_t   r;
        int          me;
        int          peer;
        logic [15:0] d;
        logic [15:0] v;
        logic [15:0] old;
        logic [15:0] mc;
        logic [15:0] pc;
        logic [3:0]  slot;
        r = '0;
        me = t.side;
        peer = 1 - me;
        d = t.write_data[15:0];
        mc = ctl_q[me];
        pc = ctl_q[peer];
        case (t.action)
            ACT_RD_SYNC: r.read_data = {16'h0000, sync_q[me]};
            ACT_WR_SYNC:
            begin
                v = (sync_q[me] & ~SYNC_WMASK) | (d & SYNC_WMASK);
                sync_q[me] = v;
                sync_q[peer] = {sync_q[peer][15:4], v[11:8]};
                if (v[SYNC_SEND] && sync_q[peer][SYNC_IEN])
                    r.irq_sync = r.irq_sync | (2'b01 << peer);
            end
            ACT_RD_CTL: r.read_data = {16'h0000, mc};
            ACT_WR_CTL:
            begin
                old = mc;
                mc = (old & ~CTL_WMASK) | (d & CTL_WMASK);
                if (d[C_CLEAR])
                begin
                    fill_q[me] = '0;
                    head_q[me] = '0;
                    mc[C_SEMPTY] = 1'b1;
                    mc[C_SFULL] = 1'b0;
                    pc[C_REMPTY] = 1'b1;
                    pc[C_RFULL] = 1'b0;
                    if (mc[C_SIRQ])
                        r.irq_send_empty = r.irq_send_empty | (2'b01 << me);
                end
                if (!old[C_SIRQ] && mc[C_SIRQ] && mc[C_SEMPTY])
                    r.irq_send_empty = r.irq_send_empty | (2'b01 << me);
                if (!old[C_RIRQ] && mc[C_RIRQ] && !mc[C_REMPTY])
                    r.irq_recv_nonempty = r.irq_recv_nonempty | (2'b01 << me);
                if (d[C_ERROR])
                    mc[C_ERROR] = 1'b0;
            end
            ACT_PUSH:
            begin
                if (mc[C_ENABLE])
                begin
                    if (fill_q[me] < DEPTH)
                    begin
                        slot = 4'((head_q[me] + fill_q[me]) % DEPTH);
                        fifo_mem[me][slot] = t.write_data;
                        fill_q[me] = fill_q[me] + 5'd1;
                        if (fill_q[me] == 1)
                        begin
                            mc[C_SEMPTY] = 1'b0;
                            pc[C_REMPTY] = 1'b0;
                            if (pc[C_RIRQ])
                                r.irq_recv_nonempty = r.irq_recv_nonempty | (2'b01 << peer);
                        end
                        else if (fill_q[me] == DEPTH)
                        begin
                            mc[C_SFULL] = 1'b1;
                            pc[C_RFULL] = 1'b1;
                        end
                    end
                    else
                        mc[C_ERROR] = 1'b1;
                end
            end
            ACT_POP:
            begin
                if (fill_q[peer] != 0)
                begin
                    latch_q[me] = fifo_mem[peer][head_q[peer]];
                    if (mc[C_ENABLE])
                    begin
                        head_q[peer] = head_q[peer] + 4'd1;
                        fill_q[peer] = fill_q[peer] - 5'd1;
                        if (fill_q[peer] == 0)
                        begin
                            pc[C_SEMPTY] = 1'b1;
                            mc[C_REMPTY] = 1'b1;
                            if (pc[C_SIRQ])
                                r.irq_send_empty = r.irq_send_empty | (2'b01 << peer);
                        end
                        else if (fill_q[peer] == DEPTH - 1)
                        begin
                            pc[C_SFULL] = 1'b0;
                            mc[C_RFULL] = 1'b0;
                        end
                    end
                end
                else
                    mc[C_ERROR] = 1'b1;
                r.read_data = latch_q[me];
            end
            default: ;
        endcase
        ctl_q[me] = mc;
        ctl_q[peer] = pc;
        return r;
    endfunction

    function automatic logic [31:0] ctl_data(input bit en, input bit sirq, input bit rirq,
                                             input bit clr, input bit ack);
        logic [31:0] w;
        w = '0;
        w[C_ENABLE] = en;
        w[C_SIRQ] = sirq;
        w[C_RIRQ] = rirq;
        w[C_CLEAR] = clr;
        w[C_ERROR] = ack;
        return w;
    endfunction

    function automatic in_item_t random_access();
        in_item_t t;
        int       pick;
        t.side = 1'($urandom_range(0, 1));
        t.write_data = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 30)
            t.action = ACT_PUSH;
        else if (pick < 60)
            t.action = ACT_POP;
        else if (pick < 70)
            t.action = ACT_RD_CTL;
        else if (pick < 80)
        begin
            t.action = ACT_WR_CTL;
            t.write_data[C_ENABLE] = ($urandom_range(0, 9) != 0);
            t.write_data[C_CLEAR] = ($urandom_range(0, 7) == 0);
        end
        else if (pick < 87)
            t.action = ACT_RD_SYNC;
        else if (pick < 95)
            t.action = ACT_WR_SYNC;
        else
            t.action = $urandom_range(0, 1) ? ACT_RESERVED_LO : ACT_RESERVED_HI;
        return t;
    endfunction

    task automatic issue(input logic [2:0] a, input logic s, input logic [31:0] d);
        in_item_t t;
        int       gap;
        t.action = a;
        t.side = s;
        t.write_data = d;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        item <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
        outcome_q.push_back(mailbox_outcome(t));
        if (a != ACT_RESERVED_LO && a != ACT_RESERVED_HI)
            sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(negedge clk);
        while (outcome_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        issue(ACT_RD_SYNC, 1'b0, 32'h0000_0000);
        issue(ACT_RD_CTL, 1'b1, 32'hFFFF_FFFF);
        // push and pop with the FIFOs still disabled
        issue(ACT_PUSH, 1'b0, 32'hA5A5_A5A5);
        issue(ACT_POP, 1'b1, 32'h0000_0000);
        issue(ACT_RD_CTL, 1'b1, 32'h0000_0000);
        issue(ACT_WR_CTL, 1'b1, 32'hFFFF_FFFF);
        issue(ACT_WR_CTL, 1'b0, ctl_data(1, 1, 1, 0, 0));
        issue(ACT_PUSH, 1'b0, 32'hFFFF_FFFF);
        issue(ACT_PUSH, 1'b0, 32'h0000_0000);
        issue(ACT_WR_CTL, 1'b1, ctl_data(1, 0, 0, 0, 0));
        issue(ACT_WR_CTL, 1'b1, ctl_data(1, 0, 1, 0, 0));
        // peek the head word with the receiver disabled
        issue(ACT_WR_CTL, 1'b1, ctl_data(0, 0, 1, 0, 0));
        issue(ACT_POP, 1'b1, 32'h0000_0000);
        issue(ACT_WR_CTL, 1'b1, ctl_data(1, 1, 1, 0, 0));
        issue(ACT_POP, 1'b1, 32'h0000_0000);
        issue(ACT_POP, 1'b1, 32'h0000_0000);
        issue(ACT_POP, 1'b1, 32'h0000_0000);
        issue(ACT_WR_CTL, 1'b0, ctl_data(1, 1, 1, 1, 1));
        issue(ACT_WR_SYNC, 1'b1, 32'h0000_4000);
        issue(ACT_WR_SYNC, 1'b0, 32'hFFFF_FFFF);
        issue(ACT_RD_SYNC, 1'b1, 32'h0000_0000);
        issue(ACT_RD_SYNC, 1'b0, 32'h0000_0000);
        issue(ACT_RESERVED_LO, 1'b0, 32'hFFFF_FFFF);
        issue(ACT_RESERVED_HI, 1'b1, 32'hFFFF_FFFF);
        issue(ACT_WR_SYNC, 1'b0, 32'h0000_0000);
    endtask

    task automatic test_fill_while_stalled();
        int i;
        issue(ACT_WR_CTL, 1'b0, ctl_data(1, 1, 1, 0, 1));
        issue(ACT_WR_CTL, 1'b1, ctl_data(1, 1, 1, 0, 1));
        rx_hold_req = LONG_HOLD;
        tx_steady = 1'b1;
        for (i = 0; i < 36; i++)
            issue((i % 3 == 2) ? ACT_RD_CTL : ACT_PUSH, 1'b0, $urandom());
        tx_steady = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        repeat (6)
            issue(ACT_POP, 1'b1, $urandom());
        wait_drained();
        repeat (6)
            issue(ACT_POP, 1'b1, $urandom());
    endtask

    task automatic test_random();
        in_item_t   t;
        int         goal;
        int         len;
        logic       s;
        logic [2:0] a;
        goal = sent + RANDOM_ITEMS;
        while (sent < goal)
        begin
            if ($urandom_range(0, 59) == 0)
                tx_steady = !tx_steady;
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 20);
                s = 1'($urandom_range(0, 1));
                a = $urandom_range(0, 1) ? ACT_PUSH : ACT_POP;
                repeat (len)
                    issue(a, s, $urandom());
            end
            else
            begin
                t = random_access();
                issue(t.action, t.side, t.write_data);
            end
        end
        tx_steady = 1'b0;
    endtask

    initial
    begin : result_check
        int        gap;
        out_item_t want;
        @(posedge rst_n);
        forever
        begin
            gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_hold_req > 0)
            begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end
            if ($urandom_range(0, 59) == 0)
                rx_steady = !rx_steady;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (outcome_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT)
                    $display("unexpected transaction: %h", result);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (result.read_data !== want.read_data
                    || result.irq_sync !== want.irq_sync
                    || result.irq_send_empty !== want.irq_send_empty
                    || result.irq_recv_nonempty !== want.irq_recv_nonempty)
                begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display("mismatch: exp %h %b %b %b got %h %b %b %b",
                                 want.read_data, want.irq_sync,
                                 want.irq_send_empty, want.irq_recv_nonempty,
                                 result.read_data, result.irq_sync,
                                 result.irq_send_empty, result.irq_recv_nonempty);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stall = 0;
            else
                stall++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rx_hold_req = 0;
        fail_count = 0;
        sent = 0;
        for (i = 0; i < 2; i++)
        begin
            sync_q[i] = '0;
            ctl_q[i] = CTL_RESET;
            fill_q[i] = '0;
            head_q[i] = '0;
            latch_q[i] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_fill_while_stalled();
        test_pause_until_drained();
        test_random();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && outcome_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/dcm_pkg.sv
sv/dcm_front.sv
sv/dcm_out_q.sv
sv/dcm_exec.sv
sv/dual_cpu_ipc_fifo_mailbox_unit.sv
dv/dual_cpu_ipc_fifo_mailbox_unit_test.sv
